FILE: src/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg: shared types and constants of the stream frame receiver
// Request and result types, register map, phase codes and the CRC16 step.
// ----------------------------------------------------------------------------
package sfr_pkg;

    localparam int PAYLOAD_LIMIT = 1024;
    localparam int LEN_W         = $clog2(PAYLOAD_LIMIT + 1);
    localparam int PADDR_W       = 4;
    localparam int PDATA_W       = 32;
    localparam int MAX_LEN_W     = 11;
    localparam int TO_W          = 16;

    localparam logic [7:0]           MAGIC_FIRST  = 8'hAB;
    localparam logic [7:0]           MAGIC_SECOND = 8'hCD;
    localparam logic [15:0]          CRC_POLY     = 16'h1021;
    localparam logic [MAX_LEN_W-1:0] MAX_LEN_RST  = 11'd1024;
    localparam logic [TO_W-1:0]      HUNT_TO_RST  = 16'd5000;
    localparam logic [TO_W-1:0]      HDR_TO_RST   = 16'd1000;
    localparam logic [TO_W-1:0]      PL_TO_RST    = 16'd5000;

    typedef enum logic [1:0] {
        REG_MAX_LEN    = 2'd0,
        REG_HUNT_TO    = 2'd1,
        REG_HDR_TO     = 2'd2,
        REG_PAYLOAD_TO = 2'd3
    } t_reg_idx;

    typedef enum logic {
        REQ_BYTE = 1'b0,
        REQ_TICK = 1'b1
    } t_req_type;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_VERDICT = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_CRC_ERR  = 2'd1,
        ST_TOO_LONG = 2'd2,
        ST_TIMEOUT  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        PH_HUNT_FIRST  = 3'd0,
        PH_HUNT_SECOND = 3'd1,
        PH_LEN_HI      = 3'd2,
        PH_LEN_LO      = 3'd3,
        PH_PAYLOAD     = 3'd4,
        PH_CRC_HI      = 3'd5,
        PH_CRC_LO      = 3'd6
    } t_phase;

    typedef struct packed {
        t_req_type  req_type;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data_byte;
        t_status     status;
        logic [15:0] frame_len;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [MAX_LEN_W-1:0] max_len;
        logic [TO_W-1:0]      hunt_timeout;
        logic [TO_W-1:0]      header_timeout;
        logic [TO_W-1:0]      payload_timeout;
    } t_cfg;

    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

FILE: src/sfr_regs.sv
// ----------------------------------------------------------------------------
// sfr_regs: configuration registers
// APB-style register file holding the length limit and the three timeouts.
// ----------------------------------------------------------------------------
module sfr_regs import sfr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[PADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_len         <= MAX_LEN_RST;
            r_cfg.hunt_timeout    <= HUNT_TO_RST;
            r_cfg.header_timeout  <= HDR_TO_RST;
            r_cfg.payload_timeout <= PL_TO_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_MAX_LEN:    r_cfg.max_len         <= pwdata[MAX_LEN_W-1:0];
                REG_HUNT_TO:    r_cfg.hunt_timeout    <= pwdata[TO_W-1:0];
                REG_HDR_TO:     r_cfg.header_timeout  <= pwdata[TO_W-1:0];
                REG_PAYLOAD_TO: r_cfg.payload_timeout <= pwdata[TO_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_MAX_LEN:    prdata = PDATA_W'(r_cfg.max_len);
            REG_HUNT_TO:    prdata = PDATA_W'(r_cfg.hunt_timeout);
            REG_HDR_TO:     prdata = PDATA_W'(r_cfg.header_timeout);
            REG_PAYLOAD_TO: prdata = PDATA_W'(r_cfg.payload_timeout);
            default:        prdata = '0;
        endcase
    end

endmodule

FILE: src/sfr_core.sv
// ----------------------------------------------------------------------------
// sfr_core: deframing state machine
// Hunts for the magic pair, reads the length, passes payload, checks CRC16.
// ----------------------------------------------------------------------------
module sfr_core import sfr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output logic      o_res_valid,
    output t_out_item o_res
);

    t_phase           r_phase, n_phase;
    logic [7:0]       r_len_hi, n_len_hi;
    logic [LEN_W-1:0] r_length, n_length;
    logic [LEN_W-1:0] r_byte_cnt, n_byte_cnt;
    logic [15:0]      r_crc, n_crc;
    logic [7:0]       r_crc_hi, n_crc_hi;
    logic [15:0]      r_tick, n_tick;

    logic [7:0]       w_b;
    logic [15:0]      w_len_full;
    logic [LEN_W-1:0] w_cnt_inc;
    logic [15:0]      w_tick_inc;
    logic [15:0]      w_limit;
    logic [15:0]      w_crc_next;

    assign w_b        = i_item.rx_byte;
    assign w_len_full = {r_len_hi, w_b};
    assign w_cnt_inc  = r_byte_cnt + LEN_W'(1);
    assign w_tick_inc = (r_tick != 16'hFFFF) ? r_tick + 16'd1 : r_tick;
    assign w_crc_next = crc16_step(r_crc, w_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HUNT_FIRST;
            r_len_hi   <= '0;
            r_length   <= '0;
            r_byte_cnt <= '0;
            r_crc      <= '0;
            r_crc_hi   <= '0;
            r_tick     <= '0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_len_hi   <= n_len_hi;
            r_length   <= n_length;
            r_byte_cnt <= n_byte_cnt;
            r_crc      <= n_crc;
            r_crc_hi   <= n_crc_hi;
            r_tick     <= n_tick;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_len_hi    = r_len_hi;
        n_length    = r_length;
        n_byte_cnt  = r_byte_cnt;
        n_crc       = r_crc;
        n_crc_hi    = r_crc_hi;
        n_tick      = r_tick;
        o_res_valid = 1'b0;
        o_res       = '{kind: KIND_PAYLOAD, data_byte: 8'h00, status: ST_OK,
                        frame_len: 16'h0000, last: 1'b0};

        case (r_phase)
            PH_HUNT_FIRST, PH_HUNT_SECOND: w_limit = i_cfg.hunt_timeout;
            PH_LEN_HI, PH_LEN_LO:          w_limit = i_cfg.header_timeout;
            default:                       w_limit = i_cfg.payload_timeout;
        endcase

        if (i_item.req_type == REQ_TICK) begin
            n_tick = w_tick_inc;
            if (w_tick_inc >= w_limit) begin
                n_phase     = PH_HUNT_FIRST;
                n_tick      = '0;
                n_byte_cnt  = '0;
                n_crc       = '0;
                o_res_valid = 1'b1;
                o_res.kind  = KIND_VERDICT;
                o_res.status = ST_TIMEOUT;
                o_res.last  = 1'b1;
            end
        end else begin
            case (r_phase)
                PH_HUNT_FIRST: begin
                    if (w_b == MAGIC_FIRST) begin
                        n_crc   = crc16_step(16'h0000, MAGIC_FIRST);
                        n_phase = PH_HUNT_SECOND;
                    end
                end
                PH_HUNT_SECOND: begin
                    if (w_b == MAGIC_SECOND) begin
                        n_crc   = w_crc_next;
                        n_phase = PH_LEN_HI;
                        n_tick  = '0;
                    end else begin
                        n_phase = PH_HUNT_FIRST;
                    end
                end
                PH_LEN_HI: begin
                    n_crc    = w_crc_next;
                    n_len_hi = w_b;
                    n_phase  = PH_LEN_LO;
                    n_tick   = '0;
                end
                PH_LEN_LO: begin
                    n_crc = w_crc_next;
                    if (w_len_full > 16'(i_cfg.max_len) ||
                        w_len_full > 16'(PAYLOAD_LIMIT)) begin
                        n_phase         = PH_HUNT_FIRST;
                        n_tick          = '0;
                        n_byte_cnt      = '0;
                        n_crc           = '0;
                        o_res_valid     = 1'b1;
                        o_res.kind      = KIND_VERDICT;
                        o_res.status    = ST_TOO_LONG;
                        o_res.frame_len = w_len_full;
                        o_res.last      = 1'b1;
                    end else begin
                        n_length   = w_len_full[LEN_W-1:0];
                        n_byte_cnt = '0;
                        n_tick     = '0;
                        n_phase    = (w_len_full == 16'h0000) ? PH_CRC_HI : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    n_crc           = w_crc_next;
                    n_byte_cnt      = w_cnt_inc;
                    n_tick          = '0;
                    if (w_cnt_inc >= r_length) begin
                        n_phase = PH_CRC_HI;
                    end
                    o_res_valid     = 1'b1;
                    o_res.data_byte = w_b;
                end
                PH_CRC_HI: begin
                    n_crc_hi = w_b;
                    n_tick   = '0;
                    n_phase  = PH_CRC_LO;
                end
                default: begin
                    n_phase         = PH_HUNT_FIRST;
                    n_tick          = '0;
                    n_byte_cnt      = '0;
                    n_crc           = '0;
                    o_res_valid     = 1'b1;
                    o_res.kind      = KIND_VERDICT;
                    o_res.status    = ({r_crc_hi, w_b} == r_crc) ? ST_OK : ST_CRC_ERR;
                    o_res.frame_len = 16'(r_length);
                    o_res.last      = 1'b1;
                end
            endcase
        end
    end

    a_verdict_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_res_valid && o_res.last) |=> (r_phase == PH_HUNT_FIRST && r_tick == '0))
        else $error("verdict did not restart the hunt");

    a_payload_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_byte_cnt < r_length))
        else $error("payload count reached length without leaving payload phase");

    a_payload_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_length != '0 && 16'(r_length) <= 16'(PAYLOAD_LIMIT)))
        else $error("payload phase with an unaccepted length");

endmodule

FILE: src/stream_frame_receiver.sv
// ----------------------------------------------------------------------------
// stream_frame_receiver: magic/length/payload/CRC16 deframer
// Top level with input register, deframer core and two-entry result buffer.
// ----------------------------------------------------------------------------
// Requests arrive on the in channel (i_in_valid / o_in_ready / i_in_data):
// each is either one received byte or one time tick. Results leave on the
// out channel (o_out_valid / i_out_ready / o_out_data): payload bytes as they
// arrive, then one verdict per frame attempt (ok, CRC error, length too
// large or timeout). Consumers discard buffered payload unless the verdict
// is ok. Registers must be written through the APB-style port only while
// idle; the block itself does not enforce it. Throughput is one request per
// cycle while the result buffer has room. A request is held in the input
// register; the core handles it in a single pass and writes its result to
// the result buffer, which feeds the out channel. The two-entry result
// buffer decouples the sides: while the receiver stalls, requests that give
// no result keep flowing, and new requests stop only once the buffer is full.
// Reset is synchronous: registers return to their defaults, the hunt restarts
// and both buffers are emptied.
// ----------------------------------------------------------------------------
module stream_frame_receiver import sfr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_item           i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    t_cfg      w_cfg;
    logic      r_in_valid;
    t_in_item  r_in;
    logic      w_res_valid;
    t_out_item w_res;
    logic      w_adv;
    logic      w_push;
    logic      w_pop;
    logic      w_slot;
    logic [1:0] r_cnt, n_cnt;
    t_out_item r_q0, n_q0;
    t_out_item r_q1, n_q1;

    sfr_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    sfr_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_adv),
        .i_item      (r_in),
        .i_cfg       (w_cfg),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    assign w_adv       = r_in_valid && (!w_res_valid || r_cnt != 2'd2);
    assign o_in_ready  = !r_in_valid || w_adv;
    assign w_push      = w_adv && w_res_valid;
    assign w_pop       = (r_cnt != 2'd0) && i_out_ready;
    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out_data  = r_q0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end

    // advance the head on pop, write the new result behind what remains
    always_comb begin
        n_cnt  = r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        n_q0   = r_q0;
        n_q1   = r_q1;
        w_slot = (r_cnt - {1'b0, w_pop}) != 2'd0;
        if (w_pop) begin
            n_q0 = r_q1;
        end
        if (w_push) begin
            if (w_slot) begin
                n_q1 = w_res;
            end else begin
                n_q0 = w_res;
            end
        end
    end

    a_buf_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2)
        else $error("result buffer overflow");

    a_payload_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.kind == KIND_PAYLOAD) |->
            (!o_out_data.last && o_out_data.status == ST_OK && o_out_data.frame_len == 16'h0000))
        else $error("payload result carries verdict fields");

endmodule

FILE: tb/stream_frame_receiver_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stream_frame_receiver_test: self-checking bench for the frame deframer
// Drives received bytes and time ticks, mirrors the deframer state in a
// local model and checks every payload byte and verdict in order. A short
// table of directed requests comes first, then random framed traffic under
// several register settings, with random stalls on both channels.
// ----------------------------------------------------------------------------
module stream_frame_receiver_test;
    import sfr_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 6;
    localparam int PHASE_REQUESTS = 110;

    typedef enum logic [3:0] {
        ROW_BYTE,
        ROW_TICK,
        ROW_CRC_HI,
        ROW_CRC_LO,
        ROW_CRC_BAD,
        ROW_SET_MAX_LEN,
        ROW_SET_HUNT_TO,
        ROW_SET_HDR_TO,
        ROW_SET_PL_TO
    } t_row_op;

    typedef struct {
        t_row_op    op;
        logic [15:0] arg;
        bit          typed;
        t_out_item   want;
    } t_stim_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    t_in_item           i_in_data = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    t_out_item          o_out_data;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    // deframer mirror
    t_cfg        cfg;
    t_phase      frame_phase;
    logic [15:0] len_val;
    logic [15:0] byte_cnt;
    logic [15:0] crc_run;
    logic [7:0]  crc_hi_seen;
    logic [15:0] tick_run;

    t_out_item   frame_results_due[$];
    t_stim_row   plan[$];

    bit          req_typed = 1'b0;
    t_out_item   req_want = '0;
    int unsigned idle_pct = 0;
    int unsigned tick_pct = 0;
    int unsigned out_hold = 0;
    int unsigned quiet = 0;
    int unsigned mismatches = 0;
    int unsigned sent = 0;

    stream_frame_receiver dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [15:0] xmodem_next(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ b[i];
            c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

    function automatic void restart_hunt();
        frame_phase = PH_HUNT_FIRST;
        tick_run    = '0;
        byte_cnt    = '0;
        crc_run     = '0;
    endfunction

    task automatic deframe_step(input t_in_item r, output bit made, output t_out_item res);
        logic [15:0] lim;
        logic [7:0]  b;
        made = 1'b0;
        res  = '0;
        b    = r.rx_byte;
        if (r.req_type == REQ_TICK) begin
            if (tick_run != 16'hFFFF) tick_run++;
            if (frame_phase <= PH_HUNT_SECOND) lim = cfg.hunt_timeout;
            else if (frame_phase <= PH_LEN_LO) lim = cfg.header_timeout;
            else lim = cfg.payload_timeout;
            if (tick_run >= lim) begin
                restart_hunt();
                made = 1'b1;
                res  = '{KIND_VERDICT, 8'h00, ST_TIMEOUT, 16'h0000, 1'b1};
            end
        end else begin
            case (frame_phase)
                PH_HUNT_FIRST: begin
                    if (b == MAGIC_FIRST) begin
                        crc_run     = xmodem_next(16'h0000, b);
                        frame_phase = PH_HUNT_SECOND;
                    end
                end
                PH_HUNT_SECOND: begin
                    if (b == MAGIC_SECOND) begin
                        crc_run     = xmodem_next(crc_run, b);
                        frame_phase = PH_LEN_HI;
                        tick_run    = '0;
                    end else begin
                        frame_phase = PH_HUNT_FIRST;
                    end
                end
                PH_LEN_HI: begin
                    crc_run     = xmodem_next(crc_run, b);
                    len_val     = {b, 8'h00};
                    frame_phase = PH_LEN_LO;
                    tick_run    = '0;
                end
                PH_LEN_LO: begin
                    crc_run = xmodem_next(crc_run, b);
                    len_val = {len_val[15:8], b};
                    if (len_val > cfg.max_len || len_val > PAYLOAD_LIMIT) begin
                        restart_hunt();
                        made = 1'b1;
                        res  = '{KIND_VERDICT, 8'h00, ST_TOO_LONG, len_val, 1'b1};
                    end else begin
                        byte_cnt    = '0;
                        tick_run    = '0;
                        frame_phase = (len_val == 0) ? PH_CRC_HI : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    crc_run  = xmodem_next(crc_run, b);
                    byte_cnt = byte_cnt + 16'd1;
                    tick_run = '0;
                    if (byte_cnt >= len_val) frame_phase = PH_CRC_HI;
                    made = 1'b1;
                    res  = '{KIND_PAYLOAD, b, ST_OK, 16'h0000, 1'b0};
                end
                PH_CRC_HI: begin
                    crc_hi_seen = b;
                    tick_run    = '0;
                    frame_phase = PH_CRC_LO;
                end
                default: begin
                    res = '{KIND_VERDICT, 8'h00, ST_CRC_ERR, len_val, 1'b1};
                    if ({crc_hi_seen, b} == crc_run) res.status = ST_OK;
                    restart_hunt();
                    made = 1'b1;
                end
            endcase
        end
    endtask

    task automatic note_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // result check, request prediction and watchdog
    always @(posedge i_clk) begin
        bit        in_fire;
        bit        out_fire;
        bit        made;
        t_out_item res;
        t_out_item want;
        if (i_rst_n) begin
            in_fire  = i_in_valid && o_in_ready;
            out_fire = o_out_valid && i_out_ready;
            if (out_fire) begin
                if (frame_results_due.size() == 0) begin
                    $display("%0t: result with none expected, expected nothing, actual %p",
                             $time, o_out_data);
                    mismatches++;
                end else begin
                    want = frame_results_due.pop_front();
                    note_field("kind", 16'(want.kind), 16'(o_out_data.kind));
                    note_field("data_byte", 16'(want.data_byte), 16'(o_out_data.data_byte));
                    note_field("status", 16'(want.status), 16'(o_out_data.status));
                    note_field("frame_len", want.frame_len, o_out_data.frame_len);
                    note_field("last", 16'(want.last), 16'(o_out_data.last));
                end
            end
            if (in_fire) begin
                deframe_step(i_in_data, made, res);
                if (req_typed) frame_results_due.push_back(req_want);
                else if (made) frame_results_due.push_back(res);
            end
            if (in_fire || out_fire) quiet = 0;
            else quiet++;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog, nothing moved for %0d cycles", $time, quiet);
                $display("FAIL stream_frame_receiver");
                $finish;
            end
        end
    end

    // result side stalls
    always @(negedge i_clk) begin
        if (out_hold > 0) begin
            out_hold--;
            i_out_ready <= 1'b0;
        end else if (idle_pct != 0 && $urandom_range(0, 299) < idle_pct) begin
            out_hold = $urandom_range(0, 10);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    task automatic send_req(input t_req_type kind, input logic [7:0] b,
                            input bit typed = 1'b0, input t_out_item want = '0);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
        i_in_data  <= '{kind, b};
        i_in_valid <= 1'b1;
        req_typed  <= typed;
        req_want   <= want;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
        sent++;
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (frame_results_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MAX_LEN:    cfg.max_len         = value[MAX_LEN_W-1:0];
            REG_HUNT_TO:    cfg.hunt_timeout    = value[TO_W-1:0];
            REG_HDR_TO:     cfg.header_timeout  = value[TO_W-1:0];
            REG_PAYLOAD_TO: cfg.payload_timeout = value[TO_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input int unsigned max_len, input int unsigned hunt,
                                  input int unsigned hdr, input int unsigned pl);
        wait_idle();
        write_reg(REG_MAX_LEN, max_len);
        write_reg(REG_HUNT_TO, hunt);
        write_reg(REG_HDR_TO, hdr);
        write_reg(REG_PAYLOAD_TO, pl);
    endtask

    function automatic void row(input t_row_op op, input logic [15:0] arg,
                                input bit typed = 1'b0, input t_out_item want = '0);
        t_stim_row r;
        r.op    = op;
        r.arg   = arg;
        r.typed = typed;
        r.want  = want;
        plan.push_back(r);
    endfunction

    task automatic send_byte(input logic [7:0] b);
        if (tick_pct != 0 && $urandom_range(0, 99) < tick_pct)
            repeat ($urandom_range(1, 3)) send_req(REQ_TICK, 8'($urandom));
        send_req(REQ_BYTE, b);
    endtask

    task automatic send_frame();
        int unsigned len;
        int unsigned pick;
        int unsigned stop_at;
        int unsigned sent_bytes;
        logic [7:0]  b;
        pick = $urandom_range(0, 99);
        if (pick < 60) len = $urandom_range(0, (cfg.max_len < 6) ? cfg.max_len : 6);
        else if (pick < 75) len = (cfg.max_len <= 48) ? cfg.max_len : $urandom_range(0, 6);
        else if (pick < 90) len = cfg.max_len + $urandom_range(1, 3);
        else len = $urandom_range(0, 65535);
        if (len <= cfg.max_len && len > 48) len = $urandom_range(0, 6);
        stop_at = ($urandom_range(0, 99) < 6) ? $urandom_range(1, len + 5) : len + 6;
        sent_bytes = 0;

        send_byte(MAGIC_FIRST);
        if ($urandom_range(0, 99) < 6) begin
            b = 8'($urandom);
            if (b == MAGIC_SECOND) b = MAGIC_FIRST;
            send_byte(b);
        end else begin
            send_byte(MAGIC_SECOND);
        end
        send_byte(len[15:8]);
        send_byte(len[7:0]);
        // drop the body of a rejected length
        if (len > cfg.max_len || len > PAYLOAD_LIMIT) return;
        for (int unsigned i = 0; i < len && sent_bytes < stop_at; i++) begin
            send_byte(8'($urandom));
            sent_bytes++;
        end
        if (sent_bytes < stop_at) send_byte(crc_run[15:8]);
        if (sent_bytes + 1 < stop_at) begin
            b = crc_run[7:0];
            if ($urandom_range(0, 99) < 20) b = b ^ (8'h01 << $urandom_range(0, 7));
            send_byte(b);
        end
    endtask

    task automatic run_traffic(input int unsigned requests);
        int unsigned pick;
        int unsigned goal;
        goal = sent + requests;
        while (sent < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                send_frame();
            end else if (pick < 85) begin
                repeat ($urandom_range(1, 4))
                    send_req(REQ_BYTE, ($urandom_range(0, 3) == 0) ? MAGIC_FIRST : 8'($urandom));
            end else begin
                repeat ($urandom_range(1, 6)) send_req(REQ_TICK, 8'($urandom));
            end
        end
    endtask

    task automatic walk_plan();
        t_stim_row r;
        foreach (plan[k]) begin
            r = plan[k];
            case (r.op)
                ROW_BYTE:    send_req(REQ_BYTE, r.arg[7:0], r.typed, r.want);
                ROW_TICK:    send_req(REQ_TICK, r.arg[7:0], r.typed, r.want);
                ROW_CRC_HI:  send_req(REQ_BYTE, crc_run[15:8], r.typed, r.want);
                ROW_CRC_LO:  send_req(REQ_BYTE, crc_run[7:0], r.typed, r.want);
                ROW_CRC_BAD: send_req(REQ_BYTE, crc_run[7:0] ^ 8'h80, r.typed, r.want);
                ROW_SET_MAX_LEN: begin
                    wait_idle();
                    write_reg(REG_MAX_LEN, 32'(r.arg));
                end
                ROW_SET_HUNT_TO: begin
                    wait_idle();
                    write_reg(REG_HUNT_TO, 32'(r.arg));
                end
                ROW_SET_HDR_TO: begin
                    wait_idle();
                    write_reg(REG_HDR_TO, 32'(r.arg));
                end
                ROW_SET_PL_TO: begin
                    wait_idle();
                    write_reg(REG_PAYLOAD_TO, 32'(r.arg));
                end
                default: ;
            endcase
        end
    endtask

    initial begin
        cfg = '{MAX_LEN_RST, HUNT_TO_RST, HDR_TO_RST, PL_TO_RST};
        len_val     = '0;
        crc_hi_seen = '0;
        restart_hunt();

        // second byte not the magic drops to hunt without a recheck
        row(ROW_BYTE, 16'h00AB);
        row(ROW_BYTE, 16'h00AB);
        row(ROW_BYTE, 16'h00CD);
        // one past the payload limit under reset settings
        row(ROW_BYTE, 16'h00AB);
        row(ROW_BYTE, 16'h00CD);
        row(ROW_BYTE, 16'h0004);
        row(ROW_BYTE, 16'h0001, 1'b1, '{KIND_VERDICT, 8'h00, ST_TOO_LONG, 16'h0401, 1'b1});
        // empty payload goes straight to the CRC
        row(ROW_BYTE, 16'h00AB);
        row(ROW_BYTE, 16'h00CD);
        row(ROW_BYTE, 16'h0000);
        row(ROW_BYTE, 16'h0000);
        row(ROW_CRC_HI, 16'h0000);
        row(ROW_CRC_LO, 16'h0000);
        // one payload byte, bad CRC
        row(ROW_BYTE, 16'h00AB);
        row(ROW_BYTE, 16'h00CD);
        row(ROW_BYTE, 16'h0000);
        row(ROW_BYTE, 16'h0001);
        row(ROW_BYTE, 16'h00FF, 1'b1, '{KIND_PAYLOAD, 8'hFF, ST_OK, 16'h0000, 1'b0});
        row(ROW_CRC_HI, 16'h0000);
        row(ROW_CRC_BAD, 16'h0000);
        // timeouts in each phase, a zero register expires on the first tick
        row(ROW_SET_HUNT_TO, 16'd2);
        row(ROW_SET_HDR_TO, 16'd1);
        row(ROW_SET_PL_TO, 16'd0);
        row(ROW_TICK, 16'h00FF);
        row(ROW_TICK, 16'h0000, 1'b1, '{KIND_VERDICT, 8'h00, ST_TIMEOUT, 16'h0000, 1'b1});
        row(ROW_BYTE, 16'h00AB);
        row(ROW_BYTE, 16'h00CD);
        row(ROW_TICK, 16'h0000, 1'b1, '{KIND_VERDICT, 8'h00, ST_TIMEOUT, 16'h0000, 1'b1});
        // length exactly at the limit is accepted
        row(ROW_BYTE, 16'h00AB);
        row(ROW_BYTE, 16'h00CD);
        row(ROW_BYTE, 16'h0004);
        row(ROW_BYTE, 16'h0000);
        row(ROW_TICK, 16'h0000, 1'b1, '{KIND_VERDICT, 8'h00, ST_TIMEOUT, 16'h0000, 1'b1});

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        idle_pct = 15;
        walk_plan();

        idle_pct = 30;
        tick_pct = 8;
        apply_settings(1024, 65535, 65535, 65535);
        run_traffic(PHASE_REQUESTS);

        idle_pct = 20;
        apply_settings(0, 1, 1, 1);
        run_traffic(PHASE_REQUESTS);

        idle_pct = 40;
        apply_settings($urandom_range(1, 40), $urandom_range(2, 12),
                       $urandom_range(2, 12), $urandom_range(2, 12));
        run_traffic(PHASE_REQUESTS);

        idle_pct = 10;
        apply_settings(32'(MAX_LEN_RST), 32'(HUNT_TO_RST), 32'(HDR_TO_RST), 32'(PL_TO_RST));
        run_traffic(PHASE_REQUESTS);

        idle_pct = 0;
        apply_settings($urandom_range(0, 1024), $urandom_range(3, 30),
                       $urandom_range(1, 8), $urandom_range(1, 8));
        run_traffic(PHASE_REQUESTS);

        wait_idle();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("PASS stream_frame_receiver");
        end else begin
            $display("FAIL stream_frame_receiver");
        end
        $finish;
    end

endmodule
